/* rtl/core/pool2d_pkg.sv */
// Shared types and constants of the 2-D pooling block.
// No dependencies; the channel interfaces, the pooling block and the testbench import this package.
`default_nettype none

package pool2d_pkg;

    // Fixed field widths of the item channels
    localparam int SAMPLE_BITS      = 16;
    localparam int OUT_COL_BITS     = 10;
    localparam int OUT_ROW_BITS     = 10;
    localparam int PLANE_BITS       = 8;
    localparam int PLANE_COUNT_BITS = 9;
    localparam int MAX_PLANES       = 256;

    // Configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 11;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_IN_WIDTH      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IN_HEIGHT     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CHANNEL_COUNT = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_POOL_WIDTH    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_POOL_HEIGHT   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MODE          = 3'd5;

    // Pooling functions; the unused code behaves as max
    localparam logic [1:0] MODE_MAX = 2'd0;
    localparam logic [1:0] MODE_AVG = 2'd1;
    localparam logic [1:0] MODE_MIN = 2'd2;

    // Register values after reset
    localparam logic [10:0] RST_IN_WIDTH      = 11'd32;
    localparam logic [10:0] RST_IN_HEIGHT     = 11'd32;
    localparam logic [8:0]  RST_CHANNEL_COUNT = 9'd1;
    localparam logic [3:0]  RST_POOL_WIDTH    = 4'd2;
    localparam logic [3:0]  RST_POOL_HEIGHT   = 4'd2;
    localparam logic [1:0]  RST_MODE          = MODE_MAX;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
    } t_sample_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] pooled;
        logic [OUT_COL_BITS-1:0]       out_col;
        logic [OUT_ROW_BITS-1:0]       out_row;
        logic [PLANE_BITS-1:0]         plane;
        logic                          frame_last;
    } t_result_item;

    typedef struct packed {
        logic [CFG_INDEX_BITS-1:0] index;
        logic [CFG_DATA_BITS-1:0]  wdata;
    } t_cfg_item;

endpackage

`default_nettype wire

/* rtl/core/pool2d_if.sv */
// Valid/ready channel interfaces of the 2-D pooling block.
// Depends on pool2d_pkg for the item types.
`default_nettype none

interface pool2d_sample_if import pool2d_pkg::*; ();
    logic         valid;
    logic         ready;
    t_sample_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pool2d_result_if import pool2d_pkg::*; ();
    logic         valid;
    logic         ready;
    t_result_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pool2d_cfg_if import pool2d_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/pool2d_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module pool2d_ram #(
    parameter int DATA_BITS = 22,
    parameter int DEPTH     = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [DATA_BITS-1:0]       i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [DATA_BITS-1:0]       o_rdata
);

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [DATA_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // Read before write: a same-address read returns the old word
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/core/pooling_2d_max_avg_min.sv */
// Streaming 2-D max / average / min pooling over non-overlapping windows.
// Depends on pool2d_pkg, the pool2d interfaces and pool2d_ram.
// Throughput: one sample item per cycle while the result channel does not stall it; the
//   cycle after a register write takes no item. A window's last sample passes in order
//   through column-partial read, read-modify-write, average scaling and output register.
// Reset (synchronous, active low) restores the register defaults and clears positions and
//   pipeline valids; the column-partial memory is not cleared and needs no clearing pass.
`default_nettype none

module pooling_2d_max_avg_min import pool2d_pkg::*; #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_POOL  = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    pool2d_sample_if.sink          i_sample_ch,
    pool2d_result_if.source        o_result_ch,
    pool2d_cfg_if.sink             i_cfg_ch
);

    // ------------------------------------------------------------------
    // Derived widths
    // ------------------------------------------------------------------
    localparam int SB       = SAMPLE_BITS;
    localparam int CW       = $clog2(MAX_WIDTH);          // position / address bits
    localparam int XB       = $clog2(MAX_WIDTH + 1);      // sizes up to MAX_WIDTH
    localparam int PB       = $clog2(MAX_POOL);           // window phase bits
    localparam int PWB      = $clog2(MAX_POOL + 1);       // pool sizes up to MAX_POOL
    localparam int AREA_MAX = MAX_POOL * MAX_POOL;
    localparam int ABW      = $clog2(AREA_MAX + 1);
    localparam int WPB      = SB + $clog2(MAX_POOL);      // one window row
    localparam int ACC      = SB + $clog2(AREA_MAX);      // whole window
    // Reciprocal scaling, exact for every dividend in range
    localparam int SP       = XB + PWB;
    localparam int PRW      = SP + 1;
    localparam int SA       = ACC + ABW;
    localparam int ARW      = SA + 1;

    // ------------------------------------------------------------------
    // Reciprocal tables: ceil(2^S / d)
    // ------------------------------------------------------------------
    logic [PRW-1:0] pos_recip [MAX_POOL + 1];
    logic [ARW-1:0] avg_recip [AREA_MAX + 1];

    for (genvar gi = 0; gi <= MAX_POOL; gi++) begin : g_pos_recip
        localparam longint unsigned DIV   = (gi == 0) ? 1 : gi;
        localparam logic [PRW-1:0]  RECIP = PRW'(((64'd1 << SP) + DIV - 1) / DIV);
        assign pos_recip[gi] = (gi == 0) ? '0 : RECIP;
    end

    for (genvar ga = 0; ga <= AREA_MAX; ga++) begin : g_avg_recip
        localparam longint unsigned DIV   = (ga == 0) ? 1 : ga;
        localparam logic [ARW-1:0]  RECIP = ARW'(((64'd1 << SA) + DIV - 1) / DIV);
        assign avg_recip[ga] = (ga == 0) ? '0 : RECIP;
    end

    // Combine two partials under the current pooling function
    function automatic logic signed [ACC-1:0] f_combine(
        input logic [1:0]            m,
        input logic signed [ACC-1:0] a,
        input logic signed [ACC-1:0] b
    );
        logic signed [ACC-1:0] res;
        case (m)
            MODE_AVG: res = a + b;
            MODE_MIN: res = (b < a) ? b : a;
            default:  res = (b > a) ? b : a;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic adv;          // whole pipeline moves one step
    logic in_acc;
    logic cfg_acc;
    logic r_settle;     // derived sizes recompute after a register write
    logic r_out_vld;

    assign adv               = !r_out_vld || o_result_ch.ready;
    assign i_sample_ch.ready = adv && !r_settle;
    assign in_acc            = i_sample_ch.valid && i_sample_ch.ready;
    assign i_cfg_ch.ready    = 1'b1;
    assign cfg_acc           = i_cfg_ch.valid && i_cfg_ch.ready;

    // ------------------------------------------------------------------
    // Configuration registers and clamped sizes
    // ------------------------------------------------------------------
    logic [10:0] r_cfg_w, r_cfg_h;
    logic [8:0]  r_cfg_c;
    logic [3:0]  r_cfg_pw, r_cfg_ph;
    logic [1:0]  r_cfg_mode;

    logic [XB-1:0]               r_w, r_h, r_ow, r_oh, n_w, n_h, n_ow, n_oh;
    logic [PLANE_COUNT_BITS-1:0] r_c, n_c;
    logic [PWB-1:0]              r_pw, r_ph, n_pw, n_ph;
    logic [ABW-1:0]              n_area;
    logic [ARW-1:0]              r_avg_recip, n_avg_recip;
    logic [XB+PRW-1:0]           ow_prod, oh_prod;

    always_comb begin
        // Zero acts as one, oversize acts as the maximum
        n_w  = (r_cfg_w == '0) ? XB'(1) :
               (32'(r_cfg_w) > 32'(MAX_WIDTH)) ? XB'(MAX_WIDTH) : XB'(r_cfg_w);
        n_h  = (r_cfg_h == '0) ? XB'(1) :
               (32'(r_cfg_h) > 32'(MAX_WIDTH)) ? XB'(MAX_WIDTH) : XB'(r_cfg_h);
        n_c  = (r_cfg_c == '0) ? PLANE_COUNT_BITS'(1) :
               (32'(r_cfg_c) > 32'(MAX_PLANES)) ? PLANE_COUNT_BITS'(MAX_PLANES) : r_cfg_c;
        n_pw = (r_cfg_pw == '0) ? PWB'(1) :
               (32'(r_cfg_pw) > 32'(MAX_POOL)) ? PWB'(MAX_POOL) : PWB'(r_cfg_pw);
        n_ph = (r_cfg_ph == '0) ? PWB'(1) :
               (32'(r_cfg_ph) > 32'(MAX_POOL)) ? PWB'(MAX_POOL) : PWB'(r_cfg_ph);

        // Output grid size: whole windows only
        ow_prod = (XB+PRW)'(n_w) * (XB+PRW)'(pos_recip[n_pw]);
        oh_prod = (XB+PRW)'(n_h) * (XB+PRW)'(pos_recip[n_ph]);
        n_ow    = ow_prod[SP +: XB];
        n_oh    = oh_prod[SP +: XB];

        n_area      = ABW'((2*PWB)'(n_pw) * (2*PWB)'(n_ph));
        n_avg_recip = avg_recip[n_area];
    end

    // ------------------------------------------------------------------
    // Stage 1: position bookkeeping, window-row partial, memory read
    // ------------------------------------------------------------------
    logic [CW-1:0]         r_col, r_row, n_col, n_row;
    logic [PLANE_BITS-1:0] r_plane, n_plane;
    logic [PB-1:0]         r_cph, r_rph, n_cph, n_rph;
    logic signed [WPB-1:0] r_wp;

    logic [XB+PRW-1:0]           col_prod, row_prod;
    logic [XB-1:0]               s1_oc_q, s1_orow_q;
    logic [CW-1:0]               s1_oc;
    logic                        s1_region, s1_col_last, s1_row_last, s1_row_first;
    logic                        s1_frame_last, col_wrap, row_wrap;
    logic signed [ACC-1:0]       s1_x, s1_wp_acc;
    logic signed [WPB-1:0]       s1_wp;
    logic [PLANE_COUNT_BITS-1:0] plane_inc;

    always_comb begin
        col_prod  = (XB+PRW)'(XB'(r_col)) * (XB+PRW)'(pos_recip[r_pw]);
        row_prod  = (XB+PRW)'(XB'(r_row)) * (XB+PRW)'(pos_recip[r_ph]);
        s1_oc_q   = col_prod[SP +: XB];
        s1_orow_q = row_prod[SP +: XB];
        s1_oc     = s1_oc_q[CW-1:0];

        // Drop samples outside the area tiled by whole windows
        s1_region = (XB'(r_col) < r_w) && (XB'(r_row) < r_h) &&
                    (PLANE_COUNT_BITS'(r_plane) < r_c) &&
                    (s1_oc_q < r_ow) && (s1_orow_q < r_oh);

        // A phase at or past the pool size closes its window
        s1_col_last   = (PWB'(r_cph) + PWB'(1)) >= r_pw;
        s1_row_last   = (PWB'(r_rph) + PWB'(1)) >= r_ph;
        s1_row_first  = (r_rph == '0);
        s1_frame_last = ((PLANE_COUNT_BITS'(r_plane) + PLANE_COUNT_BITS'(1)) == r_c) &&
                        ((s1_oc_q + XB'(1)) == r_ow) &&
                        ((s1_orow_q + XB'(1)) == r_oh);

        s1_x      = ACC'(i_sample_ch.data.sample);
        s1_wp_acc = (r_cph == '0) ? s1_x : f_combine(r_cfg_mode, ACC'(r_wp), s1_x);
        s1_wp     = WPB'(s1_wp_acc);

        // Advance column, then row, then plane
        col_wrap = (XB'(r_col) + XB'(1)) >= r_w;
        row_wrap = col_wrap && ((XB'(r_row) + XB'(1)) >= r_h);
        n_col    = col_wrap ? '0 : CW'(r_col + CW'(1));
        n_cph    = (col_wrap || s1_col_last) ? '0 : PB'(r_cph + PB'(1));
        if (!col_wrap) begin
            n_row = r_row;
            n_rph = r_rph;
        end else if (row_wrap) begin
            n_row = '0;
            n_rph = '0;
        end else begin
            n_row = CW'(r_row + CW'(1));
            n_rph = s1_row_last ? '0 : PB'(r_rph + PB'(1));
        end
        plane_inc = PLANE_COUNT_BITS'(r_plane) + (row_wrap ? PLANE_COUNT_BITS'(1) : '0);
        // A plane index past a shrunk plane count also wraps
        n_plane   = (plane_inc >= r_c) ? '0 : plane_inc[PLANE_BITS-1:0];
    end

    // ------------------------------------------------------------------
    // Stage 2: read-modify-write of the column partial
    // ------------------------------------------------------------------
    logic                   r_s2_vld, r_s2_col_last, r_s2_row_last, r_s2_row_first;
    logic                   r_s2_frame_last;
    logic signed [WPB-1:0]  r_s2_wp;
    logic [CW-1:0]          r_s2_oc, r_s2_orow;
    logic [PLANE_BITS-1:0]  r_s2_plane;
    logic                   r_fwd;
    logic signed [ACC-1:0]  r_fwd_data;

    logic [ACC-1:0]         ram_q;
    logic signed [ACC-1:0]  s2_mem_q, s2_cp;
    logic                   s2_we, s2_produce;

    always_comb begin
        // The write one step ahead lands after this item's read was issued
        s2_mem_q   = r_fwd ? r_fwd_data : $signed(ram_q);
        s2_cp      = r_s2_row_first ? ACC'(r_s2_wp)
                                    : f_combine(r_cfg_mode, s2_mem_q, ACC'(r_s2_wp));
        s2_we      = adv && r_s2_vld && r_s2_col_last;
        s2_produce = r_s2_vld && r_s2_col_last && r_s2_row_last;
    end

    pool2d_ram #(
        .DATA_BITS (ACC),
        .DEPTH     (MAX_WIDTH)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (s2_we),
        .i_waddr (r_s2_oc),
        .i_wdata (s2_cp),
        .i_re    (in_acc),
        .i_raddr (s1_oc),
        .o_rdata (ram_q)
    );

    // ------------------------------------------------------------------
    // Stage 3: average scaling into the output register
    // ------------------------------------------------------------------
    logic                   r_s3_vld, r_s3_last;
    logic signed [ACC-1:0]  r_s3_cp;
    logic [CW-1:0]          r_s3_oc, r_s3_orow;
    logic [PLANE_BITS-1:0]  r_s3_plane;
    logic [ARW-1:0]         r_avg_recip_q;

    logic                   s3_neg;
    logic [ACC-1:0]         s3_mag, s3_q, s3_avg;
    logic [ACC+ARW-1:0]     s3_prod;
    logic [SB-1:0]          s3_pooled;
    t_result_item           r_out;

    always_comb begin
        // Scale the magnitude so the quotient truncates toward zero
        s3_neg    = r_s3_cp[ACC-1];
        s3_mag    = s3_neg ? ACC'(-r_s3_cp) : ACC'(r_s3_cp);
        s3_prod   = (ACC+ARW)'(s3_mag) * (ACC+ARW)'(r_avg_recip_q);
        s3_q      = s3_prod[SA +: ACC];
        s3_avg    = s3_neg ? ACC'(-s3_q) : s3_q;
        s3_pooled = (r_cfg_mode == MODE_AVG) ? SB'(s3_avg) : SB'(r_s3_cp);
    end

    assign o_result_ch.valid = r_out_vld;
    assign o_result_ch.data  = r_out;

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= RST_IN_WIDTH;
            r_cfg_h    <= RST_IN_HEIGHT;
            r_cfg_c    <= RST_CHANNEL_COUNT;
            r_cfg_pw   <= RST_POOL_WIDTH;
            r_cfg_ph   <= RST_POOL_HEIGHT;
            r_cfg_mode <= RST_MODE;
            r_settle   <= 1'b1;
            r_col      <= '0;
            r_row      <= '0;
            r_plane    <= '0;
            r_cph      <= '0;
            r_rph      <= '0;
            r_wp       <= '0;
            r_s2_vld   <= 1'b0;
            r_s3_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_settle <= cfg_acc;
            if (cfg_acc) begin
                unique case (i_cfg_ch.data.index)
                    CFG_IN_WIDTH:      r_cfg_w    <= i_cfg_ch.data.wdata;
                    CFG_IN_HEIGHT:     r_cfg_h    <= i_cfg_ch.data.wdata;
                    CFG_CHANNEL_COUNT: r_cfg_c    <= i_cfg_ch.data.wdata[8:0];
                    CFG_POOL_WIDTH:    r_cfg_pw   <= i_cfg_ch.data.wdata[3:0];
                    CFG_POOL_HEIGHT:   r_cfg_ph   <= i_cfg_ch.data.wdata[3:0];
                    CFG_MODE:          r_cfg_mode <= i_cfg_ch.data.wdata[1:0];
                    default: begin
                    end
                endcase
            end
            if (in_acc) begin
                r_col   <= n_col;
                r_row   <= n_row;
                r_plane <= n_plane;
                r_cph   <= n_cph;
                r_rph   <= n_rph;
                if (s1_region) begin
                    r_wp <= s1_wp;
                end
            end
            if (adv) begin
                r_s2_vld  <= in_acc && s1_region;
                r_s3_vld  <= s2_produce;
                r_out_vld <= r_s3_vld;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_w         <= n_w;
        r_h         <= n_h;
        r_c         <= n_c;
        r_pw        <= n_pw;
        r_ph        <= n_ph;
        r_ow        <= n_ow;
        r_oh        <= n_oh;
        r_avg_recip <= n_avg_recip;

        if (in_acc) begin
            r_s2_col_last   <= s1_col_last;
            r_s2_row_last   <= s1_row_last;
            r_s2_row_first  <= s1_row_first;
            r_s2_frame_last <= s1_frame_last;
            r_s2_wp         <= s1_wp;
            r_s2_oc         <= s1_oc;
            r_s2_orow       <= s1_orow_q[CW-1:0];
            r_s2_plane      <= r_plane;
            // Capture the word being written this edge if it is the one being read
            r_fwd           <= s2_we && (r_s2_oc == s1_oc);
            r_fwd_data      <= s2_cp;
        end

        if (adv) begin
            r_s3_cp        <= s2_cp;
            r_s3_oc        <= r_s2_oc;
            r_s3_orow      <= r_s2_orow;
            r_s3_plane     <= r_s2_plane;
            r_s3_last      <= r_s2_frame_last;
            r_avg_recip_q  <= r_avg_recip;

            r_out.pooled     <= s3_pooled;
            r_out.out_col    <= OUT_COL_BITS'(r_s3_oc);
            r_out.out_row    <= OUT_ROW_BITS'(r_s3_orow);
            r_out.plane      <= r_s3_plane;
            r_out.frame_last <= r_s3_last;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Sizes derived from a new register value are not ready in the next cycle
    a_settle_after_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_acc |=> !in_acc)
        else $error("sample item accepted while derived sizes settle");

    // A stalled read-modify-write keeps its memory word
    a_read_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_vld && !adv) |=> $stable(ram_q))
        else $error("column partial read data changed under stall");

    // The frame's last result lies in the last plane
    a_frame_last_plane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_ch.valid && o_result_ch.data.frame_last) |->
        ((PLANE_COUNT_BITS'(o_result_ch.data.plane) + PLANE_COUNT_BITS'(1)) == r_c))
        else $error("frame_last outside the last plane");

endmodule

`default_nettype wire

/* sim/tb.sv */
// Self-checking testbench for the streaming 2-D max / average / min pooling block.
// Depends on pool2d_pkg, the pool2d channel interfaces and the RTL of
// pooling_2d_max_avg_min.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pool2d_pkg::*;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    localparam int          POOL_MAX_WIDTH = 1024;
    localparam int          POOL_MAX_POOL  = 8;
    localparam logic [1:0]  MODE_SPARE     = 2'd3;      // unused code, behaves as max
    localparam t_sample     SAMPLE_MIN     = 16'h8000;
    localparam t_sample     SAMPLE_MAX     = 16'h7FFF;
    localparam int unsigned IDLE_PCT       = 27;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned RANDOM_ITEMS   = 300;       // items after the directed part
    localparam int unsigned CYCLE_LIMIT    = 500000;

    // Tracks the block's positions, phases and partial sums, and holds the
    // windows that are due on the result channel, oldest first.
    class pool_window_board;
        logic [CFG_DATA_BITS-1:0]    in_width, in_height;
        logic [PLANE_COUNT_BITS-1:0] channels;
        logic [3:0]                  pool_w, pool_h;
        logic [1:0]                  mode;
        longint                      col_acc [POOL_MAX_WIDTH];
        longint                      row_acc;
        int unsigned                 col_pos, row_pos, plane_pos, col_phase, row_phase;
        t_result_item                due_windows [$];
        int unsigned                 mismatches;

        function new();
            in_width   = RST_IN_WIDTH;
            in_height  = RST_IN_HEIGHT;
            channels   = RST_CHANNEL_COUNT;
            pool_w     = RST_POOL_WIDTH;
            pool_h     = RST_POOL_HEIGHT;
            mode       = RST_MODE;
            row_acc    = 0;
            col_pos    = 0;
            row_pos    = 0;
            plane_pos  = 0;
            col_phase  = 0;
            row_phase  = 0;
            mismatches = 0;
            foreach (col_acc[i]) col_acc[i] = 0;
        endfunction

        function int unsigned clamp_reg(int unsigned v, int unsigned hi);
            if (v == 0) return 1;
            return (v > hi) ? hi : v;
        endfunction

        function longint fold(logic [1:0] m, longint a, longint b);
            case (m)
                MODE_AVG: return a + b;
                MODE_MIN: return (b < a) ? b : a;
                default:  return (b > a) ? b : a;
            endcase
        endfunction

        function void set_register(logic [CFG_INDEX_BITS-1:0] idx,
                                   logic [CFG_DATA_BITS-1:0] val);
            case (idx)
                CFG_IN_WIDTH:      in_width  = val;
                CFG_IN_HEIGHT:     in_height = val;
                CFG_CHANNEL_COUNT: channels  = val[PLANE_COUNT_BITS-1:0];
                CFG_POOL_WIDTH:    pool_w    = val[3:0];
                CFG_POOL_HEIGHT:   pool_h    = val[3:0];
                CFG_MODE:          mode      = val[1:0];
                default: ;
            endcase
        endfunction

        function int unsigned frame_length();
            return clamp_reg(in_width, POOL_MAX_WIDTH) * clamp_reg(in_height, POOL_MAX_WIDTH)
                   * clamp_reg(channels, MAX_PLANES);
        endfunction

        function bit at_frame_start();
            return col_pos == 0 && row_pos == 0 && plane_pos == 0;
        endfunction

        function int unsigned pending();
            return due_windows.size();
        endfunction

        // Fold one accepted sample into the partials; queue a window when it closes.
        function void note_sample(t_sample s);
            int unsigned  w, h, c, pw, ph, ow, oh, oc, orow;
            longint       x, cp, v;
            t_result_item r;
            w  = clamp_reg(in_width, POOL_MAX_WIDTH);
            h  = clamp_reg(in_height, POOL_MAX_WIDTH);
            c  = clamp_reg(channels, MAX_PLANES);
            pw = clamp_reg(pool_w, POOL_MAX_POOL);
            ph = clamp_reg(pool_h, POOL_MAX_POOL);
            ow = w / pw;
            oh = h / ph;
            x  = s;
            if (col_pos < w && row_pos < h && plane_pos < c &&
                col_pos < ow * pw && row_pos < oh * ph) begin
                oc   = (col_pos / pw) % POOL_MAX_WIDTH;
                orow = row_pos / ph;
                row_acc = (col_phase == 0) ? x : fold(mode, row_acc, x);
                if (col_phase + 1 >= pw) begin
                    cp = (row_phase == 0) ? row_acc : fold(mode, col_acc[oc], row_acc);
                    col_acc[oc] = cp;
                    if (row_phase + 1 >= ph) begin
                        v = (mode == MODE_AVG) ? cp / longint'(pw * ph) : cp;
                        r.pooled     = v[SAMPLE_BITS-1:0];
                        r.out_col    = oc[OUT_COL_BITS-1:0];
                        r.out_row    = orow[OUT_ROW_BITS-1:0];
                        r.plane      = plane_pos[PLANE_BITS-1:0];
                        r.frame_last = (plane_pos + 1 == c) && (oc + 1 == ow) && (orow + 1 == oh);
                        due_windows.push_back(r);
                    end
                end
            end
            col_pos++;
            col_phase = (col_phase + 1 >= pw) ? 0 : col_phase + 1;
            if (col_pos >= w) begin
                col_pos   = 0;
                col_phase = 0;
                row_pos++;
                row_phase = (row_phase + 1 >= ph) ? 0 : row_phase + 1;
                if (row_pos >= h) begin
                    row_pos   = 0;
                    row_phase = 0;
                    plane_pos++;
                    if (plane_pos >= c) plane_pos = 0;
                end
            end
            if (plane_pos >= c) plane_pos = 0;
        endfunction

        function void check_result(t_result_item got);
            t_result_item want;
            if (due_windows.size() == 0) begin
                $error("result with no window due: pooled %0d col %0d row %0d plane %0d",
                       got.pooled, got.out_col, got.out_row, got.plane);
                mismatches++;
                return;
            end
            want = due_windows.pop_front();
            if (got.pooled !== want.pooled) begin
                $error("pooled: expected %0d, got %0d", want.pooled, got.pooled);
                mismatches++;
            end
            if (got.out_col !== want.out_col) begin
                $error("out_col: expected %0d, got %0d", want.out_col, got.out_col);
                mismatches++;
            end
            if (got.out_row !== want.out_row) begin
                $error("out_row: expected %0d, got %0d", want.out_row, got.out_row);
                mismatches++;
            end
            if (got.plane !== want.plane) begin
                $error("plane: expected %0d, got %0d", want.plane, got.plane);
                mismatches++;
            end
            if (got.frame_last !== want.frame_last) begin
                $error("frame_last: expected %0d, got %0d", want.frame_last, got.frame_last);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    pool2d_sample_if smp_ch ();
    pool2d_result_if res_ch ();
    pool2d_cfg_if    cfg_ch ();

    pooling_2d_max_avg_min dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_ch (smp_ch),
        .o_result_ch (res_ch),
        .i_cfg_ch    (cfg_ch)
    );

    pool_window_board pool_board;
    bit               steady_flow;   // both sides run without idling while set
    bit               hold_request;  // asks the result side for one long hold-off
    int unsigned      cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: end the run as failed once the cycle count reaches CYCLE_LIMIT.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Check every result item taken off the result channel against the oldest
    // window due. Values are sampled at the rising edge, before the block updates.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            pool_board.check_result(res_ch.data);
    end

    // Result side: drop ready in about a quarter of cycles, or hold it low for a
    // long stretch when asked, so the block backs up and stalls its sample input.
    initial begin : result_taker
        int unsigned held;
        res_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                res_ch.ready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    held++;
                end
            end else begin
                res_ch.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Extremes and small values come up often; the rest is uniform over 16 bits.
    function automatic t_sample draw_sample();
        case ($urandom_range(9))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            2:       return t_sample'(int'($urandom_range(8)) - 4);
            default: return t_sample'($urandom);
        endcase
    endfunction

    // Mostly small pools, some up to the largest, a few zero or over-range codes.
    function automatic int unsigned pick_pool();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 90) return $urandom_range(4, POOL_MAX_POOL);
        return $urandom_range(1) ? 0 : $urandom_range(9, 15);
    endfunction

    // Offer one sample item, idling at random first; note it once accepted.
    task automatic send_sample(input t_sample s);
        t_sample_item item;
        item.sample = s;
        @(negedge i_clk);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            smp_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        smp_ch.valid <= 1'b1;
        smp_ch.data  <= item;
        @(posedge i_clk);
        while (smp_ch.ready !== 1'b1) @(posedge i_clk);
        pool_board.note_sample(s);
    endtask

    task automatic feed_count(input int unsigned n);
        repeat (n) send_sample(draw_sample());
    endtask

    // Send one whole frame of random samples, optionally pausing half way until
    // every due window has come out.
    task automatic feed_frame(input bit pause_midway);
        int unsigned n;
        n = pool_board.frame_length();
        for (int unsigned k = 0; k < n; k++) begin
            if (pause_midway && k == n / 2) drain_results();
            send_sample(draw_sample());
        end
    endtask

    task automatic feed_to_frame_start();
        while (!pool_board.at_frame_start()) send_sample(draw_sample());
    endtask

    // Drop the sample valid and wait until no window is due any more.
    task automatic drain_results();
        @(negedge i_clk);
        smp_ch.valid <= 1'b0;
        while (pool_board.pending() != 0) @(posedge i_clk);
    endtask

    // Bring the block to idle: drained, then a wait for samples that close no window
    // but may still be in the pipeline.
    task automatic settle();
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int unsigned val);
        t_cfg_item req;
        req.index = idx;
        req.wdata = CFG_DATA_BITS'(val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= req;
        @(posedge i_clk);
        while (cfg_ch.ready !== 1'b1) @(posedge i_clk);
        pool_board.set_register(idx, req.wdata);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic configure(input int unsigned w, input int unsigned h, input int unsigned c,
                             input int unsigned pw, input int unsigned ph,
                             input int unsigned md);
        settle();
        write_reg(CFG_IN_WIDTH, w);
        write_reg(CFG_IN_HEIGHT, h);
        write_reg(CFG_CHANNEL_COUNT, c);
        write_reg(CFG_POOL_WIDTH, pw);
        write_reg(CFG_POOL_HEIGHT, ph);
        write_reg(CFG_MODE, md);
    endtask

    task automatic random_config();
        configure($urandom_range(1, 16), $urandom_range(1, 8), $urandom_range(1, 2),
                  pick_pool(), pick_pool(), $urandom_range(3));
    endtask

    initial begin : stimulus
        int unsigned random_fed;
        int unsigned phase_no;

        pool_board   = new();
        steady_flow  = 1'b0;
        hold_request = 1'b0;
        cycle_count  = 0;
        i_rst_n      = 1'b0;
        smp_ch.valid = 1'b0;
        smp_ch.data  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---------------------------------------------------------------
        // Directed part
        // ---------------------------------------------------------------

        // Max on a 4x2 image: the first window sits entirely at the most
        // negative value, so any stale starting extreme would show up.
        configure(4, 2, 1, 2, 2, MODE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        send_sample(5);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        send_sample(-7);
        send_sample(3);

        // Average truncates toward zero: a window summing to -3 over four gives 0,
        // and a window full of the top value must not overflow.
        settle();
        write_reg(CFG_MODE, MODE_AVG);
        send_sample(-1);
        send_sample(-1);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(-1);
        send_sample(0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);

        // Min on a single 2x2 window, then the spare mode code, which acts as max
        settle();
        write_reg(CFG_IN_WIDTH, 2);
        write_reg(CFG_MODE, MODE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(0);
        send_sample(SAMPLE_MAX);
        settle();
        write_reg(CFG_MODE, MODE_SPARE);
        send_sample(SAMPLE_MIN);
        send_sample(-2);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);

        // Pool wider than the image: every sample is dropped, nothing comes out
        configure(3, 1, 1, 4, 1, MODE_MAX);
        feed_count(3);

        // Zero in every size register acts as one: each sample is its own frame
        configure(0, 0, 0, 0, 0, MODE_AVG);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);

        // Writes in the middle of a frame take effect at once and leave the
        // positions alone. Each write happens at a point where every column
        // partial that gets read back was already written in this frame.
        configure(8, 8, 3, 2, 4, MODE_AVG);
        feed_count(59);                        // stop on the last row of a window row
        settle();
        write_reg(CFG_POOL_HEIGHT, 2);         // row phase now beyond the pool height
        write_reg(CFG_MODE, MODE_MIN);
        feed_count(10);                        // into the second plane, column five
        settle();
        write_reg(CFG_IN_WIDTH, 2);            // column beyond the new width wraps
        feed_count(7);
        settle();
        write_reg(CFG_CHANNEL_COUNT, 1);       // plane beyond the new count wraps
        feed_to_frame_start();
        feed_frame(1'b0);

        // ---------------------------------------------------------------
        // Random part: one setting per phase, whole frames of random samples.
        // A few phases carry the steady stretch, the pressure cases and the
        // largest pool; every phase counts toward the item budget.
        // ---------------------------------------------------------------
        random_fed = 0;
        phase_no   = 0;
        while (phase_no < 5 || random_fed < RANDOM_ITEMS) begin
            case (phase_no)
                1: begin
                    configure(10, 10, 1, 2, 2, $urandom_range(3));
                    random_fed += pool_board.frame_length();
                    steady_flow = 1'b1;
                    feed_frame(1'b0);
                    steady_flow = 1'b0;
                end
                2: begin
                    // one result per sample while the result side holds off
                    configure(8, 8, 1, 1, 1, $urandom_range(3));
                    random_fed += pool_board.frame_length();
                    hold_request = 1'b1;
                    feed_frame(1'b0);
                end
                3: begin
                    random_config();
                    random_fed += pool_board.frame_length();
                    feed_frame(1'b1);
                end
                4: begin
                    // largest pool, clamped from over-range codes: one 64-sample window
                    configure(8, 8, 1, 15, 15, $urandom_range(3));
                    random_fed += pool_board.frame_length();
                    feed_frame(1'b0);
                end
                default: begin
                    random_config();
                    repeat ($urandom_range(1, 2)) begin
                        random_fed += pool_board.frame_length();
                        feed_frame(1'b0);
                    end
                end
            endcase
            phase_no++;
        end

        settle();
        if (pool_board.mismatches == 0 && pool_board.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
rtl/core/pool2d_pkg.sv
rtl/core/pool2d_if.sv
rtl/core/pool2d_ram.sv
rtl/core/pooling_2d_max_avg_min.sv
sim/tb.sv
